// File: design/clf_pkg.sv
// Package for the circular line FIFO: shared constants, the result status
// codes and the RAM strobe bundle. Depends on nothing; every other file imports it.
package clf_pkg;

  // Default ring depth in bytes.
  localparam int unsigned DEFAULT_DEPTH = 4096;

  // Fixed width of the chunk length field.
  localparam int unsigned LEN_W = 13;

  // Byte that terminates a line.
  localparam logic [7:0] NEWLINE_BYTE = 8'h0A;

  // Item modes.
  typedef enum logic {
    MODE_WRITE = 1'b0,
    MODE_READ  = 1'b1
  } mode_t;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_STORED  = 2'd0,
    ST_REJECT  = 2'd1,
    ST_READ    = 2'd2,
    ST_NO_LINE = 2'd3
  } status_t;

  // Strobes from the controller to the byte RAM.
  typedef struct packed {
    logic wr_en;
    logic rd_en;
  } mem_ctl_t;

endpackage

// File: design/clf_if.sv
// Valid/ready channel interfaces for the circular line FIFO: one for input
// items and one for results. Depends on clf_pkg.
interface clf_in_if;
  import clf_pkg::*;

  logic                valid;
  logic                ready;
  logic                mode;
  logic [7:0]          data_byte;
  logic                first_of_chunk;
  logic [LEN_W-1:0]    chunk_length;

  modport source (output valid, mode, data_byte, first_of_chunk, chunk_length,
                  input ready);
  modport sink   (input valid, mode, data_byte, first_of_chunk, chunk_length,
                  output ready);
endinterface

interface clf_out_if;
  import clf_pkg::*;

  logic       valid;
  logic       ready;
  logic [1:0] status;
  logic [7:0] data_out;
  logic       last_of_line;

  modport source (output valid, status, data_out, last_of_line, input ready);
  modport sink   (input valid, status, data_out, last_of_line, output ready);
endinterface

// File: design/clf_mem.sv
// Byte RAM of the circular line FIFO: one write port and one read port,
// read data registered. Depends on clf_pkg.
module clf_mem #(
  parameter int unsigned BUFFER_DEPTH = clf_pkg::DEFAULT_DEPTH,
  parameter int unsigned PTR_W        = $clog2(BUFFER_DEPTH)
) (
  input  logic              clk,
  input  clf_pkg::mem_ctl_t mem_ctl,
  input  logic [PTR_W-1:0]  waddr,
  input  logic [7:0]        wdata,
  input  logic [PTR_W-1:0]  raddr,
  output logic [7:0]        rdata
);
  import clf_pkg::*;

  logic [7:0] byte_mem_r [BUFFER_DEPTH];
  logic [7:0] rdata_r;

  // Write port.
  always_ff @(posedge clk) begin
    if (mem_ctl.wr_en) begin
      byte_mem_r[waddr] <= wdata;
    end
  end

  // Registered read port; the data holds until the next read.
  always_ff @(posedge clk) begin
    if (mem_ctl.rd_en) begin
      rdata_r <= byte_mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: design/clf_ctrl.sv
// Controller of the circular line FIFO: pointers, fill and newline counts,
// chunk admission, RAM strobes and the result register. Depends on clf_pkg.
module clf_ctrl #(
  parameter int unsigned BUFFER_DEPTH = clf_pkg::DEFAULT_DEPTH,
  parameter int unsigned PTR_W        = $clog2(BUFFER_DEPTH)
) (
  input  logic                      clk,
  input  logic                      rst_n,
  // Input items
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic                      in_mode,
  input  logic [7:0]                in_data_byte,
  input  logic                      in_first_of_chunk,
  input  logic [clf_pkg::LEN_W-1:0] in_chunk_length,
  // Results
  output logic                      out_valid,
  input  logic                      out_ready,
  output clf_pkg::status_t          out_status,
  output logic [7:0]                out_data_out,
  output logic                      out_last_of_line,
  // Byte RAM
  output clf_pkg::mem_ctl_t         mem_ctl,
  output logic [PTR_W-1:0]          mem_waddr,
  output logic [7:0]                mem_wdata,
  output logic [PTR_W-1:0]          mem_raddr,
  input  logic [7:0]                mem_rdata
);
  import clf_pkg::*;

  localparam int unsigned CNT_W = $clog2(BUFFER_DEPTH + 1);
  localparam int unsigned CMP_W = (CNT_W > LEN_W) ? CNT_W : LEN_W;
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(BUFFER_DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(BUFFER_DEPTH);

  typedef enum logic {
    S_IDLE,
    S_RD_WAIT
  } state_t;

  state_t           state_r, state_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [CNT_W-1:0] fill_r, fill_nxt;
  logic [CNT_W-1:0] nl_cnt_r, nl_cnt_nxt;
  logic             chunk_acc_r, chunk_acc_nxt;
  logic             out_valid_r, out_valid_nxt;
  status_t          status_r, status_nxt;
  logic [7:0]       data_out_r, data_out_nxt;
  logic             last_r, last_nxt;

  logic             out_free;
  logic             accept;
  logic [CNT_W-1:0] room;
  logic             admit;
  logic             store_ok;
  logic             has_line;
  logic             rd_is_nl;

  // A new item is taken only when idle and the result register will be free.
  assign out_free = !out_valid_r || out_ready;
  assign in_ready = (state_r == S_IDLE) && out_free;
  assign accept   = in_valid && in_ready;

  // Chunk admission and line availability.
  assign room     = CNT_FULL - fill_r;
  assign admit    = (in_chunk_length != '0) &&
                    (CMP_W'(in_chunk_length) <= CMP_W'(room));
  assign has_line = (nl_cnt_r != '0) && (fill_r != '0);
  assign rd_is_nl = (mem_rdata == NEWLINE_BYTE);

  always_comb begin
    chunk_acc_nxt = in_first_of_chunk ? admit : chunk_acc_r;
  end
  assign store_ok = chunk_acc_nxt && (fill_r != CNT_FULL);

  // RAM access: writes land at the edge of acceptance, reads are issued there.
  always_comb begin
    mem_ctl.wr_en = accept && (in_mode == MODE_WRITE) && store_ok;
    mem_ctl.rd_en = accept && (in_mode == MODE_READ) && has_line;
  end
  assign mem_waddr = wr_ptr_r;
  assign mem_wdata = in_data_byte;
  assign mem_raddr = rd_ptr_r;

  // Next-state logic.
  always_comb begin
    state_nxt     = state_r;
    rd_ptr_nxt    = rd_ptr_r;
    wr_ptr_nxt    = wr_ptr_r;
    fill_nxt      = fill_r;
    nl_cnt_nxt    = nl_cnt_r;
    out_valid_nxt = out_valid_r && !out_ready;
    status_nxt    = status_r;
    data_out_nxt  = data_out_r;
    last_nxt      = last_r;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          out_valid_nxt = 1'b1;
          data_out_nxt  = '0;
          last_nxt      = 1'b0;
          if (in_mode == MODE_WRITE) begin
            if (store_ok) begin
              status_nxt = ST_STORED;
              wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
              fill_nxt   = fill_r + 1'b1;
              if (in_data_byte == NEWLINE_BYTE) begin
                nl_cnt_nxt = nl_cnt_r + 1'b1;
              end
            end else begin
              status_nxt = ST_REJECT;
            end
          end else if (has_line) begin
            // The byte arrives from the RAM next cycle.
            out_valid_nxt = 1'b0;
            state_nxt     = S_RD_WAIT;
            rd_ptr_nxt    = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
            fill_nxt      = fill_r - 1'b1;
          end else begin
            status_nxt = ST_NO_LINE;
          end
        end
      end
      S_RD_WAIT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          status_nxt    = ST_READ;
          data_out_nxt  = mem_rdata;
          last_nxt      = rd_is_nl;
          if (rd_is_nl) begin
            nl_cnt_nxt = nl_cnt_r - 1'b1;
          end
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State and registered outputs.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      rd_ptr_r    <= '0;
      wr_ptr_r    <= '0;
      fill_r      <= '0;
      nl_cnt_r    <= '0;
      chunk_acc_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      rd_ptr_r    <= rd_ptr_nxt;
      wr_ptr_r    <= wr_ptr_nxt;
      fill_r      <= fill_nxt;
      nl_cnt_r    <= nl_cnt_nxt;
      out_valid_r <= out_valid_nxt;
      if (accept && (in_mode == MODE_WRITE)) begin
        chunk_acc_r <= chunk_acc_nxt;
      end
    end
    status_r   <= status_nxt;
    data_out_r <= data_out_nxt;
    last_r     <= last_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_status       = status_r;
  assign out_data_out     = data_out_r;
  assign out_last_of_line = last_r;

endmodule

// File: design/circular_line_fifo_top.sv
// Top level of the circular line FIFO: joins the controller and the byte RAM
// to the channel interfaces. Depends on clf_pkg, clf_if, clf_mem, clf_ctrl.
//
//   channel  dir  word                                             handshake
//   in_ch    in   mode, data_byte, first_of_chunk, chunk_length    valid/ready
//   out_ch   out  status, data_out, last_of_line                   valid/ready
//
// A write word is written at the accepting edge and its result is registered
// there, so writes can be taken on every cycle while out_ch takes each result.
// A read word that finds a line waits in S_RD_WAIT for the registered RAM byte.
// One word is in flight at a time, so no RAM entry is read and written together.
// Synchronous reset clears pointers and counters; the RAM itself is not cleared.
// While a result waits on out_ch, in_ch is stalled unless that result is taken.
module circular_line_fifo_top #(
  parameter int unsigned BUFFER_DEPTH = clf_pkg::DEFAULT_DEPTH
) (
  input logic clk,
  input logic rst_n,
  clf_in_if.sink    in_ch,
  clf_out_if.source out_ch
);
  import clf_pkg::*;

  localparam int unsigned PTR_W = $clog2(BUFFER_DEPTH);

  mem_ctl_t         mem_ctl;
  logic [PTR_W-1:0] mem_waddr;
  logic [PTR_W-1:0] mem_raddr;
  logic [7:0]       mem_wdata;
  logic [7:0]       mem_rdata;
  status_t          out_status;

  // Pointer, counter and result control.
  clf_ctrl #(
    .BUFFER_DEPTH (BUFFER_DEPTH),
    .PTR_W        (PTR_W)
  ) u_ctrl (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_ch.valid),
    .in_ready          (in_ch.ready),
    .in_mode           (in_ch.mode),
    .in_data_byte      (in_ch.data_byte),
    .in_first_of_chunk (in_ch.first_of_chunk),
    .in_chunk_length   (in_ch.chunk_length),
    .out_valid         (out_ch.valid),
    .out_ready         (out_ch.ready),
    .out_status        (out_status),
    .out_data_out      (out_ch.data_out),
    .out_last_of_line  (out_ch.last_of_line),
    .mem_ctl           (mem_ctl),
    .mem_waddr         (mem_waddr),
    .mem_wdata         (mem_wdata),
    .mem_raddr         (mem_raddr),
    .mem_rdata         (mem_rdata)
  );

  assign out_ch.status = out_status;

  // Byte ring storage.
  clf_mem #(
    .BUFFER_DEPTH (BUFFER_DEPTH),
    .PTR_W        (PTR_W)
  ) u_mem (
    .clk     (clk),
    .mem_ctl (mem_ctl),
    .waddr   (mem_waddr),
    .wdata   (mem_wdata),
    .raddr   (mem_raddr),
    .rdata   (mem_rdata)
  );

`ifndef ASSERT_OFF
  // A write word gives its stored or rejected result on the next cycle.
  a_write_result : assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready && in_ch.mode == MODE_WRITE) |=>
      (out_ch.valid && (out_ch.status == ST_STORED || out_ch.status == ST_REJECT)))
    else $error("write word did not give a write result");

  // A read word shows either nothing yet or the no-line result next cycle.
  a_read_result : assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready && in_ch.mode == MODE_READ) |=>
      (!out_ch.valid || out_ch.status == ST_NO_LINE))
    else $error("read word gave an unexpected result");

  // Only a popped byte carries data or the line end mark.
  a_idle_payload : assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.status != ST_READ) |->
      (out_ch.data_out == 8'd0 && !out_ch.last_of_line))
    else $error("non-read result carries data");

  // A waiting result that is not taken holds off new input words.
  a_stall : assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && !out_ch.ready) |-> !in_ch.ready)
    else $error("input taken while result register is blocked");
`endif

endmodule

// File: tb/circular_line_fifo_top_tb.sv
// Self-checking testbench for circular_line_fifo_top: directed and random byte
// traffic checked against a cycle-free line FIFO predictor.
// Depends on clf_pkg, the clf_in_if/clf_out_if interfaces and the design files.
module circular_line_fifo_top_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import clf_pkg::*;

  localparam int unsigned RING_DEPTH   = DEFAULT_DEPTH;
  localparam int unsigned LONG_HOLD    = 200;
  localparam int unsigned DRAIN_CYCLES = 10;

  typedef struct packed {
    mode_t            mode;
    logic [7:0]       data;
    logic             first;
    logic [LEN_W-1:0] len;
  } in_word_t;

  typedef struct packed {
    status_t    status;
    logic [7:0] data;
    logic       last;
  } line_result_t;

  typedef struct packed {
    in_word_t     word;
    logic         typed;
    line_result_t res;
  } step_row_t;

  logic clk;
  logic rst_n;

  clf_in_if  in_ch ();
  clf_out_if out_ch ();

  circular_line_fifo_top #(.BUFFER_DEPTH(RING_DEPTH)) DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // Predictor state: a copy of the ring and its pointers and counters.
  logic [7:0]  ring_bytes [RING_DEPTH];
  int unsigned ring_rd;
  int unsigned ring_wr;
  int unsigned ring_fill;
  int unsigned ring_lines;
  logic        chunk_open;

  line_result_t pending_results [$];
  int unsigned  fail_count;
  int unsigned  words_sent;
  int unsigned  send_idle_pct;
  int unsigned  recv_idle_pct;
  int unsigned  hold_requests;

  // Directed words. Where the result is obvious it is typed in; the rest
  // rely on the predictor.
  step_row_t directed_steps [25] = '{
    // Read on an empty ring; the ignored fields are at their extremes.
    '{'{MODE_READ,  8'hFF, 1'b1, 13'h1FFF}, 1'b1, '{ST_NO_LINE, 8'h00, 1'b0}},
    // Zero chunk length refuses the chunk and the byte after it.
    '{'{MODE_WRITE, 8'h41, 1'b1, 13'd0},    1'b1, '{ST_REJECT,  8'h00, 1'b0}},
    '{'{MODE_WRITE, 8'h0A, 1'b0, 13'd0},    1'b1, '{ST_REJECT,  8'h00, 1'b0}},
    // Chunks longer than the ring.
    '{'{MODE_WRITE, 8'h41, 1'b1, 13'h1FFF}, 1'b1, '{ST_REJECT,  8'h00, 1'b0}},
    '{'{MODE_WRITE, 8'h42, 1'b1, 13'd4097}, 1'b1, '{ST_REJECT,  8'h00, 1'b0}},
    // A byte with no admitted chunk behind it.
    '{'{MODE_WRITE, 8'h00, 1'b0, 13'd0},    1'b1, '{ST_REJECT,  8'h00, 1'b0}},
    // A line written in pieces, with a read before its newline arrives.
    '{'{MODE_WRITE, 8'h61, 1'b1, 13'd3},    1'b1, '{ST_STORED,  8'h00, 1'b0}},
    '{'{MODE_WRITE, 8'h62, 1'b0, 13'd0},    1'b1, '{ST_STORED,  8'h00, 1'b0}},
    '{'{MODE_READ,  8'h00, 1'b0, 13'd0},    1'b1, '{ST_NO_LINE, 8'h00, 1'b0}},
    '{'{MODE_WRITE, 8'h0A, 1'b0, 13'd0},    1'b1, '{ST_STORED,  8'h00, 1'b0}},
    // More bytes than declared, a zero byte and a second newline.
    '{'{MODE_WRITE, 8'hFF, 1'b0, 13'd0},    1'b1, '{ST_STORED,  8'h00, 1'b0}},
    '{'{MODE_WRITE, 8'h00, 1'b0, 13'd0},    1'b1, '{ST_STORED,  8'h00, 1'b0}},
    '{'{MODE_WRITE, 8'h0A, 1'b0, 13'h1FFF}, 1'b1, '{ST_STORED,  8'h00, 1'b0}},
    // Both lines read back, then a read with nothing left.
    '{'{MODE_READ,  8'hFF, 1'b1, 13'h1FFF}, 1'b1, '{ST_READ,    8'h61, 1'b0}},
    '{'{MODE_READ,  8'h00, 1'b0, 13'd0},    1'b1, '{ST_READ,    8'h62, 1'b0}},
    '{'{MODE_READ,  8'h00, 1'b0, 13'd0},    1'b1, '{ST_READ,    8'h0A, 1'b1}},
    '{'{MODE_READ,  8'h00, 1'b0, 13'd0},    1'b1, '{ST_READ,    8'hFF, 1'b0}},
    '{'{MODE_READ,  8'h00, 1'b0, 13'd0},    1'b1, '{ST_READ,    8'h00, 1'b0}},
    '{'{MODE_READ,  8'h00, 1'b0, 13'd0},    1'b1, '{ST_READ,    8'h0A, 1'b1}},
    '{'{MODE_READ,  8'h00, 1'b0, 13'd0},    1'b1, '{ST_NO_LINE, 8'h00, 1'b0}},
    // Room checks against the full depth with one byte stored.
    '{'{MODE_WRITE, 8'h0A, 1'b1, 13'd1},    1'b1, '{ST_STORED,  8'h00, 1'b0}},
    '{'{MODE_WRITE, 8'h55, 1'b1, 13'd4096}, 1'b1, '{ST_REJECT,  8'h00, 1'b0}},
    '{'{MODE_WRITE, 8'h30, 1'b1, 13'd4095}, 1'b0, '0},
    '{'{MODE_READ,  8'h00, 1'b0, 13'd0},    1'b1, '{ST_READ,    8'h0A, 1'b1}},
    '{'{MODE_READ,  8'h00, 1'b0, 13'd0},    1'b0, '0}
  };

  // Works out the result of one word and moves the predictor state on.
  function automatic line_result_t predict_line_result(input in_word_t w);
    line_result_t r;
    r = '{ST_NO_LINE, 8'h00, 1'b0};
    if (w.mode == MODE_WRITE) begin
      if (w.first) begin
        chunk_open = (w.len != 0) && (int'(w.len) <= int'(RING_DEPTH - ring_fill));
      end
      if (chunk_open && ring_fill < RING_DEPTH) begin
        ring_bytes[ring_wr] = w.data;
        ring_wr = (ring_wr + 1) % RING_DEPTH;
        ring_fill++;
        if (w.data == NEWLINE_BYTE) ring_lines++;
        r.status = ST_STORED;
      end else begin
        r.status = ST_REJECT;
      end
    end else if (ring_lines != 0 && ring_fill != 0) begin
      r.data = ring_bytes[ring_rd];
      ring_rd = (ring_rd + 1) % RING_DEPTH;
      ring_fill--;
      if (r.data == NEWLINE_BYTE) begin
        ring_lines--;
        r.last = 1'b1;
      end
      r.status = ST_READ;
    end
    return r;
  endfunction

  function automatic in_word_t write_word(input logic [7:0] d, input logic f,
                                          input logic [LEN_W-1:0] l);
    return '{MODE_WRITE, d, f, l};
  endfunction

  // Read words carry random values in the fields that a read ignores.
  function automatic in_word_t read_word();
    in_word_t w;
    w = in_word_t'($urandom);
    w.mode = MODE_READ;
    return w;
  endfunction

  // Offers one word from a falling edge, idling first at random, and records
  // its expected result at the accepting edge. Returns at the next falling
  // edge with valid still high.
  task automatic push_word(input in_word_t w, input logic typed = 1'b0,
                           input line_result_t typed_res = '0);
    line_result_t predicted;
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid = 1'b0;
      @(negedge clk);
    end
    in_ch.valid          = 1'b1;
    in_ch.mode           = w.mode;
    in_ch.data_byte      = w.data;
    in_ch.first_of_chunk = w.first;
    in_ch.chunk_length   = w.len;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    predicted = predict_line_result(w);
    pending_results.push_back(typed ? typed_res : predicted);
    words_sent++;
    @(negedge clk);
  endtask

  // Sender stays quiet until every expected result has arrived.
  task automatic wait_drain();
    in_ch.valid = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  // Reads the ring dry, closing an unterminated tail with a newline whenever
  // no whole line is left to read.
  task automatic empty_ring();
    while (ring_fill != 0) begin
      if (ring_lines == 0) begin
        push_word(write_word(NEWLINE_BYTE, 1'b1, 13'd1));
      end else begin
        push_word(read_word());
      end
    end
  endtask

  // Mostly well-formed chunks and read bursts, with some noise words, until
  // the word count reaches the target.
  task automatic run_mixed_traffic(input int unsigned target);
    int unsigned pick;
    int unsigned n;
    int unsigned declared;
    logic [7:0]  b;
    while (words_sent < target) begin
      pick = $urandom_range(99);
      // Keep the ring from clogging: read lines out when it is getting full.
      if (ring_fill > 3 * RING_DEPTH / 4 && ring_lines != 0) pick = 60;
      if (pick < 45) begin
        n = ($urandom_range(9) == 0) ? $urandom_range(200, 17) : $urandom_range(16, 1);
        case ($urandom_range(9))
          0: begin
            declared = 0;
          end
          1: begin
            declared = $urandom_range(n + 8, 1);
          end
          2: begin
            declared = $urandom_range(8191, RING_DEPTH + 1);
          end
          default: begin
            declared = n;
          end
        endcase
        for (int unsigned i = 0; i < n; i++) begin
          if (i == n - 1 && $urandom_range(9) < 8) b = NEWLINE_BYTE;
          else if ($urandom_range(6) == 0) b = NEWLINE_BYTE;
          else b = 8'($urandom_range(255));
          push_word(write_word(b, i == 0, (i == 0) ? LEN_W'(declared) : LEN_W'($urandom)));
        end
      end else if (pick < 90) begin
        repeat ($urandom_range(30, 1)) push_word(read_word());
      end else begin
        repeat ($urandom_range(6, 1)) push_word(in_word_t'($urandom));
      end
    end
  endtask

  // Clock.
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Result receiver: random stalls, plus long hold-offs on request.
  initial begin : result_receiver
    int unsigned hold_seen;
    int unsigned hold_left;
    hold_seen = 0;
    hold_left = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_requests != hold_seen) begin
        hold_seen = hold_requests;
        hold_left = LONG_HOLD;
      end
      if (hold_left != 0) begin
        out_ch.ready = 1'b0;
        hold_left--;
      end else begin
        out_ch.ready = ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Each accepted result is compared with the oldest expectation.
  always @(posedge clk) begin
    line_result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result word: status %0d data_out %0h last_of_line %0b",
               out_ch.status, out_ch.data_out, out_ch.last_of_line);
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        if (out_ch.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_ch.status);
          fail_count++;
        end
        if (out_ch.data_out !== want.data) begin
          $error("data_out: expected %0h, got %0h", want.data, out_ch.data_out);
          fail_count++;
        end
        if (out_ch.last_of_line !== want.last) begin
          $error("last_of_line: expected %0b, got %0b", want.last, out_ch.last_of_line);
          fail_count++;
        end
      end
    end
  end

  // Main sequence.
  initial begin
    in_ch.valid          = 1'b0;
    in_ch.mode           = MODE_WRITE;
    in_ch.data_byte      = 8'h00;
    in_ch.first_of_chunk = 1'b0;
    in_ch.chunk_length   = '0;
    rst_n         = 1'b0;
    ring_rd       = 0;
    ring_wr       = 0;
    ring_fill     = 0;
    ring_lines    = 0;
    chunk_open    = 1'b0;
    fail_count    = 0;
    words_sent    = 0;
    hold_requests = 0;
    send_idle_pct = 38;
    recv_idle_pct = 77;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (directed_steps[i]) begin
      push_word(directed_steps[i].word, directed_steps[i].typed, directed_steps[i].res);
    end

    // Sender light, receiver heavy; opens with a long receiver hold-off.
    hold_requests++;
    run_mixed_traffic(700);
    wait_drain();

    // Sender heavy, receiver light.
    send_idle_pct = 77;
    recv_idle_pct = 38;
    run_mixed_traffic(1400);

    // No idling on either side.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_mixed_traffic(2050);

    // Fill the whole ring with one chunk of the full depth while the
    // receiver holds off, so the input stalls behind the first result.
    empty_ring();
    hold_requests++;
    push_word(write_word(8'($urandom_range(255)), 1'b1, LEN_W'(RING_DEPTH)));
    for (int unsigned i = 1; i < RING_DEPTH - 1; i++) begin
      push_word(write_word(8'($urandom_range(255)), 1'b0, LEN_W'($urandom)));
    end
    push_word(write_word(NEWLINE_BYTE, 1'b0, '0));
    wait_drain();

    // Full ring: a byte is refused but the chunk stays open, so once a byte
    // has been read the next one goes in. A new chunk then finds no room.
    push_word(write_word(8'h77, 1'b0, '0));
    push_word(read_word());
    push_word(write_word(NEWLINE_BYTE, 1'b0, '0));
    push_word(write_word(8'h31, 1'b1, 13'd1));
    push_word(write_word(8'h32, 1'b0, '0));
    empty_ring();

    // Let the last results come out, then let the bench idle so that anything
    // spurious can show.
    in_ch.valid = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pending_results.size() != 0) begin
      $error("%0d expected result words never arrived", pending_results.size());
    end
    if (fail_count == 0 && pending_results.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Watchdog on the whole run.
  initial begin
    #8_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule

// File: files.f
design/clf_pkg.sv
design/clf_if.sv
design/clf_mem.sv
design/clf_ctrl.sv
design/circular_line_fifo_top.sv
tb/circular_line_fifo_top_tb.sv
